FILE: src/tkst_pkg.sv
// Shared types, widths and constants of the top-k score table.
// Used by tkst_step and top_k_score_table; depends on nothing else.
package tkst_pkg;

    // Table geometry.
    localparam int ENTRIES = 10;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Field widths.
    localparam int SCORE_W    = 24;
    localparam int TAG_W      = 8;
    localparam int RANK_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Commands.
    localparam logic CMD_OFFER  = 1'b0;
    localparam logic CMD_REINIT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAG  = 2'd2;

    // Configuration reset values.
    localparam logic [SCORE_W-1:0] RESET_HIGH_INIT = 24'd1000;
    localparam logic [SCORE_W-1:0] RESET_LOW_INIT  = 24'd0;
    localparam logic [TAG_W-1:0]   RESET_TAG_INIT  = 8'd0;

    // Reciprocal of ENTRIES for the reinit step: x / ENTRIES is
    // (x * STEP_RECIP) >> STEP_SHIFT, low by at most one.
    localparam int STEP_SHIFT   = 30;
    localparam int STEP_RECIP_W = 30;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP =
        STEP_RECIP_W'((64'd1 << STEP_SHIFT) / ENTRIES);
    localparam int STEP_PROD_W  = SCORE_W + STEP_RECIP_W;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Input item.
    typedef struct packed {
        logic               command;
        logic [SCORE_W-1:0] new_score;
        logic [TAG_W-1:0]   new_tag;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic               qualified;
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] entry_score;
        logic [TAG_W-1:0]   entry_tag;
        logic               last;
    } t_out_item;

endpackage

FILE: src/tkst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module tkst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tkst_step.sv
// Reinit step unit: computes (reset_high - reset_low) / ENTRIES by reciprocal
// multiplication with a one-step correction. Depends on tkst_pkg.
module tkst_step
    import tkst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SCORE_W-1:0] i_diff,
    output logic               o_done,
    output logic [SCORE_W-1:0] o_step
);

    logic                   r_v1;
    logic                   r_v2;
    logic                   r_done;
    logic [SCORE_W-1:0]     r_x;
    logic [STEP_PROD_W-1:0] r_prod;
    logic [SCORE_W-1:0]     r_q;

    logic [SCORE_W-1:0] q_est;
    logic [SCORE_W-1:0] q_times_n;
    logic [SCORE_W-1:0] rem;
    logic [SCORE_W-1:0] n_q;

    // Correct the estimate: the remainder is below twice ENTRIES.
    always_comb begin
        q_est     = r_prod[STEP_PROD_W-1:STEP_SHIFT];
        q_times_n = SCORE_W'(q_est * ENTRIES);
        rem       = r_x - q_times_n;
        n_q       = (rem >= SCORE_W'(ENTRIES)) ? q_est + 1'b1 : q_est;
    end

    // Control: a three-stage valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    // Datapath: operand, product, corrected quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_diff;
        end
        if (r_v1) begin
            r_prod <= STEP_PROD_W'(r_x) * STEP_PROD_W'(STEP_RECIP);
        end
        if (r_v2) begin
            r_q <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_step = r_q;

endmodule

FILE: src/top_k_score_table.sv
// Top-k score table: ENTRIES (score, tag) pairs kept in descending order in one
// on-chip RAM. Depends on tkst_pkg, tkst_ram and tkst_step.
//
// Each item is either an offer or a reinit, and each returns the whole table
// as ENTRIES result items in rank order, the last one flagged. The input is
// stalled from acceptance until the table pass ends. The pass handles one
// entry per cycle while the output is not stalled: for an offer it reads,
// updates and writes back each entry through the single table RAM, for a
// reinit it writes each entry. Before the pass an offer reads the lowest
// entry and a reinit computes its step. The table reads as all zero after
// reset through per-entry valid bits, so no clearing pass is needed.
// Configuration registers are to be written only while the block is idle;
// the block itself does not enforce this, and the write port is always ready.
module top_k_score_table
    import tkst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // Result items.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PASS = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    logic [1:0]         r_state;
    logic               r_cmd;
    logic [SCORE_W-1:0] r_score;
    logic [TAG_W-1:0]   r_tag;
    logic [SCORE_W-1:0] r_min;
    logic               r_qual;
    logic               r_ins;
    logic               r_shift;
    t_entry             r_carry;
    logic [IDX_W-1:0]   r_k;
    logic [SCORE_W-1:0] r_acc;
    logic [ENTRIES-1:0] r_valid;
    logic               r_rd_vld;
    logic [SCORE_W-1:0] r_cfg_high;
    logic [SCORE_W-1:0] r_cfg_low;
    logic [TAG_W-1:0]   r_cfg_tag;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_accept;
    logic               out_free;
    logic               advance;
    logic               last_k;
    t_entry             rd_entry;
    t_entry             n_entry;
    t_entry             n_carry;
    logic               n_ins;
    logic               n_shift;
    logic [SCORE_W-1:0] step_diff;
    logic               step_done;
    logic [SCORE_W-1:0] step_val;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Handshakes.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = (r_state == ST_PASS) && out_free;
    assign last_k      = (r_k == IDX_LAST);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Never-written entries read as zero.
    assign rd_entry = r_rd_vld ? t_entry'(ram_rdata) : '0;

    // Reinit spread; zero when the low end is above the high end.
    assign step_diff = (r_cfg_high >= r_cfg_low) ? r_cfg_high - r_cfg_low : '0;

    tkst_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept && (i_in_item.command == CMD_REINIT)),
        .i_diff  (step_diff),
        .o_done  (step_done),
        .o_step  (step_val)
    );

    // Table entry update for the current rank. An offer not below the lowest
    // entry is inserted at the first entry below it, or at the first lowest entry;
    // the entries from there down to just above the first lowest one move one place down.
    always_comb begin
        n_entry = rd_entry;
        n_carry = r_carry;
        n_ins   = r_ins;
        n_shift = r_shift;
        if (r_cmd == CMD_REINIT) begin
            n_entry.score = r_acc;
            n_entry.tag   = r_cfg_tag;
        end else if (r_qual) begin
            if (!r_ins) begin
                if ((rd_entry.score < r_score) || (rd_entry.score == r_min)) begin
                    n_entry.score = r_score;
                    n_entry.tag   = r_tag;
                    n_carry       = rd_entry;
                    n_ins         = 1'b1;
                    n_shift       = 1'b1;
                end
            end else if (r_shift) begin
                if (r_carry.score != r_min) begin
                    n_entry = r_carry;
                    n_carry = rd_entry;
                end else begin
                    n_shift = 1'b0;
                end
            end
        end
    end

    // Table RAM read address: lowest entry first, then the rank pass.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        priority if (in_accept && (i_in_item.command == CMD_OFFER)) begin
            ram_re    = 1'b1;
            ram_raddr = IDX_LAST;
        end else if (r_state == ST_MIN) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
        end else if (advance && (r_cmd == CMD_OFFER) && !last_k) begin
            ram_re    = 1'b1;
            ram_raddr = r_k + 1'b1;
        end else begin
            ram_re    = 1'b0;
        end
    end

    assign ram_we = advance;

    tkst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_k),
        .i_wdata (ENTRY_W'(n_entry)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_high <= RESET_HIGH_INIT;
            r_cfg_low  <= RESET_LOW_INIT;
            r_cfg_tag  <= RESET_TAG_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_RESET_HIGH) begin
                r_cfg_high <= i_cfg_data;
            end
            if (i_cfg_index == REG_RESET_LOW) begin
                r_cfg_low <= i_cfg_data;
            end
            if (i_cfg_index == REG_RESET_TAG) begin
                r_cfg_tag <= i_cfg_data[TAG_W-1:0];
            end
        end
    end

    // Entry valid bits and the valid flag that follows the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (ram_we) begin
                r_valid[r_k] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_valid[ram_raddr];
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= (i_in_item.command == CMD_REINIT) ? ST_DIV : ST_MIN;
                    end
                end
                ST_MIN: begin
                    r_state <= ST_PASS;
                end
                ST_DIV: begin
                    if (step_done) begin
                        r_state <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (advance && last_k) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item and pass registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_in_item.command;
            r_score <= i_in_item.new_score;
            r_tag   <= i_in_item.new_tag;
        end
        if (r_state == ST_MIN) begin
            r_min   <= rd_entry.score;
            r_qual  <= (r_score >= rd_entry.score);
            r_k     <= '0;
            r_ins   <= 1'b0;
            r_shift <= 1'b0;
        end
        if ((r_state == ST_DIV) && step_done) begin
            r_acc  <= r_cfg_high;
            r_qual <= 1'b0;
            r_k    <= '0;
        end
        if (advance) begin
            r_k     <= r_k + 1'b1;
            r_acc   <= r_acc - step_val;
            r_carry <= n_carry;
            r_ins   <= n_ins;
            r_shift <= n_shift;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.qualified   <= r_qual;
            r_out.rank        <= RANK_W'(r_k);
            r_out.entry_score <= n_entry.score;
            r_out.entry_tag   <= n_entry.tag;
            r_out.last        <= last_k;
        end
    end

endmodule
